/* sv/rwcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rwcs_pkg;
   localparam int SCREEN_COLUMNS_DEFAULT = 1024;
   localparam logic [9:0] SCREEN_ROWS_RESET = 10'd480;
   localparam logic [7:0] TEXTURE_SIZE_RESET = 8'd30;
   localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
   localparam int FRAC_BITS = 22;
   localparam int HDIV_BITS = 18;
   localparam int SDIV_BITS = 24;
   localparam int NUM_CELLS = HDIV_BITS + SDIV_BITS;

   localparam logic CSR_SCREEN_ROWS = 1'b0;
   localparam logic CSR_TEXTURE_SIZE = 1'b1;

   typedef struct packed {
      logic [9:0] column;
      logic [15:0] perp_dist;
      logic side;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
   } req_type;

   typedef struct packed {
      logic [9:0] column_out;
      logic [9:0] draw_start;
      logic [9:0] draw_end;
      logic [7:0] tex_column;
      logic [23:0] tex_step;
      logic [23:0] tex_start;
   } rsp_type;

   typedef struct packed {
      logic [9:0] column;
      logic [9:0] rows;
      logic [7:0] tsize;
      logic [21:0] frac;
      logic mirror;
      logic [17:0] hrem;
      logic [15:0] hden;
      logic [17:0] hquo;
      logic [24:0] srem;
      logic [23:0] squo;
   } cell_type;
endpackage
`default_nettype wire

/* sv/rwcs_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module rwcs_cell #(
   parameter int STEP = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic stall,
   input wire logic valid_in,
   input wire rwcs_pkg::cell_type data_in,
   output logic valid_out,
   output rwcs_pkg::cell_type data_out
);
   logic valid_ff;
   rwcs_pkg::cell_type data_ff, data_in_c;

   // height division: first 18 steps; step division: after that, 24 steps
   if (STEP < rwcs_pkg::HDIV_BITS) begin : g_height
      localparam int QBIT = rwcs_pkg::HDIV_BITS - 1 - STEP;
      logic [17:0] hshift;
      logic [18:0] htrial;
      always_comb begin
         data_in_c = data_in;
         hshift = {data_in.hrem[16:0], data_in.hquo[QBIT]};
         htrial = {1'b0, hshift} - {3'b0, data_in.hden};
         if (!htrial[18]) begin
            data_in_c.hrem = htrial[17:0];
            data_in_c.hquo[QBIT] = 1'b1;
         end else begin
            data_in_c.hrem = hshift;
            data_in_c.hquo[QBIT] = 1'b0;
         end
      end
   end else begin : g_step
      localparam int QBIT = rwcs_pkg::SDIV_BITS - 1 - (STEP - rwcs_pkg::HDIV_BITS);
      logic [15:0] height;
      logic [24:0] sshift, strial;
      always_comb begin
         data_in_c = data_in;
         height = (data_in.hquo > 18'(rwcs_pkg::HEIGHT_MAX)) ? rwcs_pkg::HEIGHT_MAX
                                                           : data_in.hquo[15:0];
         sshift = {data_in.srem[23:0], data_in.squo[QBIT]};
         strial = sshift - {9'b0, height};
         if (!strial[24] && height != 16'd0) begin
            data_in_c.srem = strial;
            data_in_c.squo[QBIT] = 1'b1;
         end else begin
            data_in_c.srem = sshift;
            data_in_c.squo[QBIT] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         data_ff <= data_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign data_out = data_ff;
endmodule
`default_nettype wire

/* sv/rwcs_tail.sv */
`timescale 1ns / 1ps
`default_nettype none
module rwcs_tail (
   input wire logic clock,
   input wire logic reset,
   input wire logic stall,
   input wire logic valid_in,
   input wire rwcs_pkg::cell_type data_in,
   output logic valid_out,
   output rwcs_pkg::rsp_type data_out
);
   logic v1_ff, v2_ff;
   logic [15:0] height;
   logic [14:0] half;
   logic [8:0] center;
   logic [15:0] hc;
   logic [9:0] dstart, dend;
   logic [23:0] step;
   logic [15:0] offset;
   logic [29:0] fprod;
   logic [7:0] tcol;
   rwcs_pkg::rsp_type r1_ff, r1_in, r2_ff, r2_in;
   logic [15:0] off_ff;
   logic zero_ff;
   logic [39:0] prod;

   always_comb begin
      height = (data_in.hquo > 18'(rwcs_pkg::HEIGHT_MAX)) ? rwcs_pkg::HEIGHT_MAX
                                                        : data_in.hquo[15:0];
      half = height[15:1];
      center = data_in.rows[9:1];
      dstart = ({1'b0, half} >= {7'b0, center}) ? 10'd0 : 10'({7'b0, center} - {1'b0, half});
      hc = {1'b0, half} + {7'b0, center};
      if (data_in.rows == 10'd0) begin
         dend = '0;
      end else if (hc >= {6'b0, data_in.rows}) begin
         dend = data_in.rows - 10'd1;
      end else begin
         dend = hc[9:0];
      end
      fprod = {8'b0, data_in.frac} * {22'b0, data_in.tsize};
      tcol = fprod[29:22];
      if (data_in.tsize == 8'd0) begin
         tcol = 8'd0;
      end else if (data_in.mirror) begin
         tcol = data_in.tsize - 8'd1 - tcol;
      end
      step = data_in.squo;
      offset = 16'({6'b0, dstart} + {1'b0, half} - {7'b0, center});
      r1_in = '0;
      r1_in.column_out = data_in.column;
      r1_in.draw_start = dstart;
      r1_in.draw_end = dend;
      r1_in.tex_column = tcol;
      r1_in.tex_step = (height == 16'd0) ? 24'd0 : step;
   end

   always_comb begin
      prod = {24'b0, off_ff} * {16'b0, r1_ff.tex_step};
      r2_in = r1_ff;
      if (zero_ff) begin
         r2_in.tex_start = '0;
      end else if (prod > 40'hFFFFFF) begin
         r2_in.tex_start = 24'hFFFFFF;
      end else begin
         r2_in.tex_start = prod[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (!stall) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         r1_ff <= r1_in;
         off_ff <= offset;
         zero_ff <= (height == 16'd0);
         r2_ff <= r2_in;
      end
   end

   assign valid_out = v2_ff;
   assign data_out = r2_ff;
endmodule
`default_nettype wire

/* sv/raycast_wall_column_span.sv */
// Pipeline stages from req word to rsp word: 1 entry, 42 division cells, 2 tail.
// Throughput: one word per cycle; the pipeline advances unless an rsp word waits on rsp_stall.
// Input side stalls exactly when the output register holds an untaken word.
// Reset: synchronous active high; clears valid bits, screen_rows=480, texture_size=30.
`timescale 1ns / 1ps
`default_nettype none
module raycast_wall_column_span #(
   parameter int SCREEN_COLUMNS = rwcs_pkg::SCREEN_COLUMNS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire rwcs_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rwcs_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [0:0] csr_index,
   input wire logic [9:0] csr_wdata
);
   localparam int N = rwcs_pkg::NUM_CELLS;
   logic [9:0] rows_ff;
   logic [7:0] tsize_ff;
   logic v0_ff;
   rwcs_pkg::cell_type c0_ff, c0_in;
   logic [N:0] vchain;
   rwcs_pkg::cell_type dchain [N + 1];
   logic stall;
   logic [7:0] pos_lo;
   logic [15:0] rd;
   logic [21:0] prod;
   logic [21:0] frac;
   logic mirror;

   assign stall = rsp_valid & rsp_stall;
   assign req_stall = stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= rwcs_pkg::SCREEN_ROWS_RESET;
         tsize_ff <= rwcs_pkg::TEXTURE_SIZE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rwcs_pkg::CSR_SCREEN_ROWS: rows_ff <= csr_wdata;
            rwcs_pkg::CSR_TEXTURE_SIZE: tsize_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // only the low 22 bits of the wall hit matter
   always_comb begin
      pos_lo = req_data.side ? req_data.pos_x[7:0] : req_data.pos_y[7:0];
      rd = req_data.side ? req_data.ray_dir_x : req_data.ray_dir_y;
      prod = 22'({6'b0, req_data.perp_dist} * {{6{rd[15]}}, rd});
      frac = {pos_lo, 14'b0} + prod;
      mirror = (!req_data.side && req_data.ray_dir_x > 16'sd0)
               || (req_data.side && req_data.ray_dir_y < 16'sd0);
      c0_in = '0;
      c0_in.column = req_data.column;
      c0_in.rows = rows_ff;
      c0_in.tsize = tsize_ff;
      c0_in.frac = frac;
      c0_in.mirror = mirror;
      c0_in.squo = {tsize_ff, 16'b0};
      if (req_data.perp_dist == 16'd0) begin
         c0_in.hden = 16'd1;
         c0_in.hquo = (rows_ff == 10'd0) ? 18'd0 : 18'(rwcs_pkg::HEIGHT_MAX);
      end else begin
         c0_in.hden = req_data.perp_dist;
         c0_in.hquo = {rows_ff, 8'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (!stall) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         c0_ff <= c0_in;
      end
   end

   assign vchain[0] = v0_ff;
   assign dchain[0] = c0_ff;

   for (genvar g = 0; g < N; g++) begin : g_chain
      rwcs_cell #(.STEP(g)) u_cell (
         .clock(clock), .reset(reset), .stall(stall),
         .valid_in(vchain[g]), .data_in(dchain[g]),
         .valid_out(vchain[g + 1]), .data_out(dchain[g + 1])
      );
   end

   rwcs_tail u_tail (
      .clock(clock), .reset(reset), .stall(stall),
      .valid_in(vchain[N]), .data_in(dchain[N]),
      .valid_out(rsp_valid), .data_out(rsp_data)
   );
endmodule
`default_nettype wire

/* tb/raycast_wall_column_span_chk.sv */
`timescale 1ns / 1ps
module raycast_wall_column_span_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire rwcs_pkg::req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire rwcs_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   input wire logic csr_ready,
   input wire logic [0:0] csr_index,
   input wire logic [9:0] csr_wdata,
   output int mismatches,
   output int spans_pending
);
   logic [9:0] rows_cfg;
   logic [7:0] tsize_cfg;
   rwcs_pkg::rsp_type span_queue[$];

   function automatic rwcs_pkg::rsp_type predict_span(rwcs_pkg::req_type w,
                                                      logic [9:0] rows, logic [7:0] tsize);
      longint unsigned height, half, center, dstart, dend, pos, frac, tcol, step, start;
      longint wall, rd;
      rwcs_pkg::rsp_type s;
      if (w.perp_dist == 0) height = (rows == 0) ? 0 : 65535;
      else height = (longint'(rows) << 8) / w.perp_dist;
      if (height > 65535) height = 65535;
      half = height >> 1;
      center = rows >> 1;
      dstart = (half >= center) ? 0 : center - half;
      dend = half + center;
      if (rows == 0) dend = 0;
      else if (dend >= rows) dend = rows - 1;
      if (!w.side) begin
         pos = w.pos_y;
         rd = w.ray_dir_y;
      end else begin
         pos = w.pos_x;
         rd = w.ray_dir_x;
      end
      wall = longint'(pos << 14) + longint'(w.perp_dist) * rd;
      frac = wall & 64'h3FFFFF;
      if (tsize == 0) tcol = 0;
      else begin
         tcol = (frac * tsize) >> 22;
         if ((!w.side && w.ray_dir_x > 0) || (w.side && w.ray_dir_y < 0))
            tcol = tsize - 1 - tcol;
      end
      if (height == 0) begin
         step = 0;
         start = 0;
      end else begin
         step = (longint'(tsize) << 16) / height;
         if (step > 24'hFFFFFF) step = 24'hFFFFFF;
         start = (dstart + half - center) * step;
         if (start > 24'hFFFFFF) start = 24'hFFFFFF;
      end
      s.column_out = w.column;
      s.draw_start = dstart[9:0];
      s.draw_end = dend[9:0];
      s.tex_column = tcol[7:0];
      s.tex_step = step[23:0];
      s.tex_start = start[23:0];
      return s;
   endfunction

   task automatic check_field(string fname, longint unsigned want, longint unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t span %s mismatch: expected %0d got %0d", $realtime, fname, want, got);
      end
   endtask

   assign spans_pending = span_queue.size();

   initial mismatches = 0;

   always @(posedge clock) begin
      rwcs_pkg::rsp_type want;
      if (reset) begin
         rows_cfg <= rwcs_pkg::SCREEN_ROWS_RESET;
         tsize_cfg <= rwcs_pkg::TEXTURE_SIZE_RESET;
         span_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == rwcs_pkg::CSR_SCREEN_ROWS) rows_cfg <= csr_wdata;
            else tsize_cfg <= csr_wdata[7:0];
         end
         if (req_valid && !req_stall)
            span_queue.push_back(predict_span(req_data, rows_cfg, tsize_cfg));
         if (rsp_valid && !rsp_stall) begin
            if (span_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t unexpected span word", $realtime);
            end else begin
               want = span_queue.pop_front();
               check_field("column_out", want.column_out, rsp_data.column_out);
               check_field("draw_start", want.draw_start, rsp_data.draw_start);
               check_field("draw_end", want.draw_end, rsp_data.draw_end);
               check_field("tex_column", want.tex_column, rsp_data.tex_column);
               check_field("tex_step", want.tex_step, rsp_data.tex_step);
               check_field("tex_start", want.tex_start, rsp_data.tex_start);
            end
         end
      end
   end
endmodule

/* tb/raycast_wall_column_span_tb.sv */
`timescale 1ns / 1ps
module raycast_wall_column_span_tb;
   localparam int STALL_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_valid, csr_ready;
   rwcs_pkg::req_type req_data;
   rwcs_pkg::rsp_type rsp_data;
   logic [0:0] csr_index;
   logic [9:0] csr_wdata;
   int mismatches, spans_pending;
   int send_idle_pct, recv_idle_pct, quiet_cycles;

   raycast_wall_column_span uut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   raycast_wall_column_span_chk chk (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_wdata, .mismatches,
      .spans_pending
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[raycast_wall_column_span] ERROR");
         $finish;
      end
   end

   task automatic send_hit(rwcs_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (spans_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [9:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic rwcs_pkg::req_type random_hit();
      rwcs_pkg::req_type w;
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      w = bits[$bits(rwcs_pkg::req_type) - 1:0];
      case ($urandom_range(3))
         0: w.perp_dist = 16'($urandom_range(16'h0400));
         1: w.perp_dist = 16'($urandom_range(16'h0040));
         default: ;
      endcase
      return w;
   endfunction

   function automatic rwcs_pkg::req_type make_hit(logic [9:0] col, logic [15:0] perp,
                                                  logic sd, logic [15:0] px, logic [15:0] py,
                                                  logic [15:0] rx, logic [15:0] ry);
      rwcs_pkg::req_type w;
      w.column = col;
      w.perp_dist = perp;
      w.side = sd;
      w.pos_x = px;
      w.pos_y = py;
      w.ray_dir_x = rx;
      w.ray_dir_y = ry;
      return w;
   endfunction

   task automatic directed_hits();
      send_hit(make_hit(10'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_hit(make_hit(10'd1023, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF));
      send_hit(make_hit(10'd5, 16'h0100, 1'b0, 16'h0280, 16'h0340, 16'h4000, 16'h2000));
      send_hit(make_hit(10'd6, 16'h0100, 1'b0, 16'h0280, 16'h0340, 16'hC000, 16'hE000));
      send_hit(make_hit(10'd7, 16'h0100, 1'b1, 16'h0280, 16'h0340, 16'h4000, 16'hE000));
      send_hit(make_hit(10'd8, 16'h0100, 1'b1, 16'h0280, 16'h0340, 16'hC000, 16'h2000));
      send_hit(make_hit(10'd9, 16'h0001, 1'b0, 16'd0, 16'hFFFF, 16'h8000, 16'h8000));
      send_hit(make_hit(10'd10, 16'h0001, 1'b1, 16'hFFFF, 16'd0, 16'h8000, 16'h7FFF));
      send_hit(make_hit(10'd11, 16'h8000, 1'b0, 16'h1234, 16'h5678, 16'h0001, 16'hFFFF));
      send_hit(make_hit(10'd12, 16'h00F0, 1'b1, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
      send_hit(make_hit(10'd13, 16'h0200, 1'b0, 16'h0100, 16'h0100, 16'd0, 16'h4000));
      send_hit(make_hit(10'd14, 16'h1000, 1'b1, 16'h0100, 16'h0100, 16'h4000, 16'd0));
      send_hit(make_hit(10'd15, 16'h0010, 1'b0, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = rwcs_pkg::CSR_SCREEN_ROWS;
      csr_wdata = '0;
      quiet_cycles = 0;
      send_idle_pct = 13;
      recv_idle_pct = 74;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_hits();
      write_reg(rwcs_pkg::CSR_SCREEN_ROWS, 10'd1023);
      write_reg(rwcs_pkg::CSR_TEXTURE_SIZE, 10'd255);
      directed_hits();
      write_reg(rwcs_pkg::CSR_SCREEN_ROWS, 10'd0);
      write_reg(rwcs_pkg::CSR_TEXTURE_SIZE, 10'd0);
      directed_hits();
      write_reg(rwcs_pkg::CSR_SCREEN_ROWS, 10'd1);
      write_reg(rwcs_pkg::CSR_TEXTURE_SIZE, 10'd1);
      directed_hits();
      for (int seg = 0; seg < 12; seg++) begin
         if (seg == 4) begin
            send_idle_pct = 74;
            recv_idle_pct = 13;
         end else if (seg == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (seg % 4)
            0: begin
               write_reg(rwcs_pkg::CSR_SCREEN_ROWS, 10'($urandom_range(1, 1023)));
               write_reg(rwcs_pkg::CSR_TEXTURE_SIZE, 10'($urandom_range(1, 255)));
            end
            1: begin
               write_reg(rwcs_pkg::CSR_SCREEN_ROWS, 10'd480);
               write_reg(rwcs_pkg::CSR_TEXTURE_SIZE, 10'd30);
            end
            2: begin
               write_reg(rwcs_pkg::CSR_SCREEN_ROWS, 10'd1023);
               write_reg(rwcs_pkg::CSR_TEXTURE_SIZE, 10'hFF);
            end
            default: begin
               write_reg(rwcs_pkg::CSR_SCREEN_ROWS, 10'($urandom_range(0, 1023)));
               write_reg(rwcs_pkg::CSR_TEXTURE_SIZE, 10'($urandom));
            end
         endcase
         repeat (75) send_hit(random_hit());
      end
      drain();
      if (mismatches == 0 && spans_pending == 0)
         $display("[raycast_wall_column_span] OK");
      else
         $display("[raycast_wall_column_span] ERROR");
      $finish;
   end
endmodule
